// ===== rtl/core/rft_pkg.sv =====
// shared types and constants for the retry failure tracker
// no dependencies
package rft_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	localparam logic [3:0]  LIMIT_RESET  = 4'd8;
	localparam logic [31:0] EXPIRY_RESET = 32'd5000;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_NOTE  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic {
		REG_FAILURE_LIMIT = 1'b0,
		REG_EXPIRY_AGE    = 1'b1
	} reg_index_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [3:0]  count;
		logic [15:0] buffer_key;
		logic [31:0] owner_key;
		logic [31:0] last_time;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	typedef struct packed {
		logic       done;
		logic       hit;
		logic       free;
		idx_t       hit_idx;
		idx_t       free_idx;
		slot_word_t hit_word;
		slot_word_t slot0_word;
	} scan_res_t;

endpackage

// ===== rtl/core/rft_ram.sv =====
// generic single write, single read port ram with registered read data
// no dependencies
module rft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rft_scan.sv =====
// slot scan sequencer: walks the slot ram one entry a cycle through one key compare
// depends on rft_pkg
module rft_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [15:0]                    buffer_key,
	input  logic [31:0]                    owner_key,
	input  logic [rft_pkg::SLOT_COUNT-1:0] valid_bits,
	input  rft_pkg::slot_word_t            rd_data,
	output logic                           rd_en,
	output rft_pkg::idx_t                  rd_addr,
	output rft_pkg::scan_res_t             res
);

	typedef enum logic {
		SC_IDLE,
		SC_RUN
	} sc_state_t;

	sc_state_t                 state_q;
	logic [rft_pkg::CNT_W-1:0] iss_q;
	logic                      pend_q;
	rft_pkg::idx_t             chk_q;
	rft_pkg::scan_res_t        res_q;
	logic                      live;
	logic                      match;
	logic                      last;

	assign rd_en   = (state_q == SC_RUN) && (iss_q < rft_pkg::CNT_W'(rft_pkg::SLOT_COUNT));
	assign rd_addr = iss_q[rft_pkg::IDX_W-1:0];

	assign live  = valid_bits[chk_q] && (rd_data.count != 4'd0);
	assign match = live && (rd_data.buffer_key == buffer_key)
		&& (rd_data.owner_key == owner_key);
	assign last  = (chk_q == rft_pkg::IDX_W'(rft_pkg::SLOT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SC_IDLE;
			iss_q      <= '0;
			pend_q     <= 1'b0;
			res_q.done <= 1'b0;
			res_q.hit  <= 1'b0;
			res_q.free <= 1'b0;
		end else begin
			case (state_q)
				SC_IDLE: begin
					pend_q <= 1'b0;
					if (start) begin
						state_q    <= SC_RUN;
						iss_q      <= '0;
						res_q.done <= 1'b0;
						res_q.hit  <= 1'b0;
						res_q.free <= 1'b0;
					end
				end
				SC_RUN: begin
					pend_q <= rd_en;
					chk_q  <= rd_addr;
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (pend_q) begin
						if (chk_q == '0) begin
							res_q.slot0_word <= rd_data;
						end
						if (match) begin
							res_q.hit      <= 1'b1;
							res_q.hit_idx  <= chk_q;
							res_q.hit_word <= rd_data;
							res_q.done     <= 1'b1;
							state_q        <= SC_IDLE;
						end else begin
							if (!live && !res_q.free) begin
								res_q.free     <= 1'b1;
								res_q.free_idx <= chk_q;
							end
							if (last) begin
								res_q.done <= 1'b1;
								state_q    <= SC_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/retry_failure_tracker.sv =====
// retry failure tracker top level: config registers, slot ram, valid bits, update step
// depends on rft_pkg, rft_ram, rft_scan
// the scan reads one slot a cycle from the slot ram and stops at the first live key match
// items are taken one at a time: in_stall stays high until the update step fires, which waits while a result is stalled
// reset clears all slot valid bits at once, so every slot reads as empty; no clearing pass
module retry_failure_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] buffer_key,
	input  logic [31:0] owner_key,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        exhausted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_ACT
	} t_state_t;

	t_state_t                   state_q;
	logic [3:0]                 limit_q;
	logic [31:0]                expiry_q;
	logic [1:0]                 op_q;
	logic [15:0]                bkey_q;
	logic [31:0]                okey_q;
	logic [31:0]                now_q;
	logic [rft_pkg::SLOT_COUNT-1:0] valid_q;
	logic                       out_valid_q;
	logic                       exhausted_q;

	logic                       in_accept;
	logic                       act_fire;
	logic                       rd_en;
	rft_pkg::idx_t              rd_addr;
	rft_pkg::slot_word_t        rd_data;
	logic [rft_pkg::WORD_W-1:0] rd_raw;
	rft_pkg::scan_res_t         res;

	logic                       we;
	rft_pkg::idx_t              sel_idx;
	rft_pkg::slot_word_t        sel_word;
	rft_pkg::slot_word_t        wword;
	logic                       found;
	logic [3:0]                 lim;
	logic [3:0]                 new_cnt;
	logic [31:0]                age;
	logic                       result;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != T_IDLE);
	assign cfg_ready = 1'b1;
	assign act_fire  = (state_q == T_ACT) && (!out_valid_q || !out_stall);

	rft_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_accept),
		.buffer_key (bkey_q),
		.owner_key  (okey_q),
		.valid_bits (valid_q),
		.rd_data    (rd_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.res        (res)
	);

	rft_ram #(
		.WIDTH (rft_pkg::WORD_W),
		.DEPTH (rft_pkg::SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (sel_idx),
		.wdata (wword),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	assign rd_data = rft_pkg::slot_word_t'(rd_raw);

	always_comb begin
		lim      = (limit_q == 4'd0) ? 4'd1 : limit_q;
		found    = res.hit || res.free;
		sel_idx  = '0;
		sel_word = res.slot0_word;
		if (res.hit) begin
			sel_idx  = res.hit_idx;
			sel_word = res.hit_word;
		end else if (res.free) begin
			sel_idx        = res.free_idx;
			sel_word       = res.slot0_word;
			sel_word.count = 4'd0;
		end
		age     = now_q - sel_word.last_time;
		new_cnt = sel_word.count;
		wword   = sel_word;
		we      = 1'b0;
		result  = 1'b0;
		case (op_q)
			rft_pkg::OP_CHECK: begin
				if (found && (sel_word.count >= lim)) begin
					if (age > expiry_q) begin
						new_cnt = lim - 4'd1;
					end
					wword.count = new_cnt;
					we          = act_fire;
					result      = (new_cnt >= lim);
				end
			end
			rft_pkg::OP_NOTE: begin
				if (sel_word.count == 4'd0) begin
					wword.buffer_key = bkey_q;
					wword.owner_key  = okey_q;
				end
				if (sel_word.count < lim) begin
					wword.count = sel_word.count + 4'd1;
				end
				wword.last_time = now_q;
				we              = act_fire;
			end
			rft_pkg::OP_CLEAR: begin
				wword = '0;
				we    = act_fire && found;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			limit_q     <= rft_pkg::LIMIT_RESET;
			expiry_q    <= rft_pkg::EXPIRY_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			exhausted_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rft_pkg::REG_FAILURE_LIMIT: limit_q  <= cfg_data[3:0];
					rft_pkg::REG_EXPIRY_AGE:    expiry_q <= cfg_data;
					default:                    limit_q  <= limit_q;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_accept) begin
						op_q    <= opcode;
						bkey_q  <= buffer_key;
						okey_q  <= owner_key;
						now_q   <= now;
						state_q <= T_SCAN;
					end
				end
				T_SCAN: begin
					if (res.done) begin
						state_q <= T_ACT;
					end
				end
				T_ACT: begin
					if (act_fire) begin
						out_valid_q <= 1'b1;
						exhausted_q <= result;
						state_q     <= T_IDLE;
						if (we) begin
							valid_q[sel_idx] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign exhausted = exhausted_q;

	a_scan_reads_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == T_SCAN))
		else $error("slot ram read outside scan");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res.done && res.hit) |-> valid_q[res.hit_idx])
		else $error("scan hit on a slot never written");

	a_only_check_exhausts: assert property (@(posedge clk) disable iff (!arst_n)
		(act_fire && (op_q != rft_pkg::OP_CHECK)) |=> (out_valid && !exhausted))
		else $error("exhausted set for an op other than check");

	a_write_in_act: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ((state_q == T_ACT) && res.done))
		else $error("slot write outside the update step");

endmodule
